// File: rtl/multiplicative_congruential_uniform_assert.svh
// Assertion macros shared by the uniform generator RTL.
// Included by the modules that check their own sequencing.
`ifndef MULTIPLICATIVE_CONGRUENTIAL_UNIFORM_ASSERT_SVH
`define MULTIPLICATIVE_CONGRUENTIAL_UNIFORM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mcu_pkg.sv
// Shared constants and controller/datapath interface types for the
// multiplicative congruential uniform generator. No dependencies.
package mcu_pkg;

  localparam int STATE_W = 64;
  localparam int HALF_W = STATE_W / 2;
  localparam int MULT_W = 31;
  localparam int RUN_W = 16;
  localparam int FRACTION_W = 32;
  localparam int DEF_FRACTION_BITS = 32;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 2'd2;

  localparam logic [MULT_W-1:0] RST_MULTIPLIER = 31'd16807;
  localparam logic [STATE_W-1:0] RST_MODULUS = 64'd2147483647;
  localparam logic [RUN_W-1:0] RST_RUN_LENGTH = 16'd100;
  localparam logic [STATE_W-1:0] RST_STATE = 64'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef struct packed {
    logic load_seed;
    logic mul_lo;
    logic mul_hi;
    logic rem_step;
    logic save_state;
    logic frac_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic can_push;
  } status_t;

endpackage

// File: rtl/mcu_datapath.sv
// Datapath of the uniform generator: configuration registers, shared
// multiplier, bit-serial remainder/divide unit and output register.
// Depends on mcu_pkg and the assertion macro header.
module mcu_datapath #(
  parameter int FRACTION_BITS = mcu_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mcu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [mcu_pkg::STATE_W-1:0]     seed_value,
  input  mcu_pkg::cmd_t                   cmd,
  output mcu_pkg::status_t                status,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [mcu_pkg::STATE_W-1:0]     state_value,
  output logic [mcu_pkg::FRACTION_W-1:0]  fraction,
  output logic                            last
);
  import mcu_pkg::*;
  `include "multiplicative_congruential_uniform_assert.svh"

  localparam int SHIFT = STATE_W - FRACTION_BITS;

  logic [MULT_W-1:0] mult;
  logic [STATE_W-1:0] modulus;
  logic [RUN_W-1:0] run_length;
  logic [STATE_W-1:0] gstate;
  logic [STATE_W-1:0] acc;
  logic [STATE_W-1:0] rem;
  logic [FRACTION_BITS-1:0] quo;
  logic [RUN_W-1:0] count;

  logic [HALF_W-1:0] mul_in;
  logic [MULT_W+HALF_W-1:0] prod_part;
  logic [STATE_W:0] trial;
  logic [STATE_W:0] diff;
  logic fits;
  logic [STATE_W-1:0] rem_next;
  logic [RUN_W:0] count_inc;
  logic run_end;
  logic mod_zero;
  logic [STATE_W-1:0] frac_top;
  logic [FRACTION_W-1:0] frac_out;

  assign mul_in = cmd.mul_hi ? gstate[STATE_W-1:HALF_W] : gstate[HALF_W-1:0];
  assign prod_part = mult * mul_in;

  assign trial = {rem, cmd.rem_step ? acc[STATE_W-1] : 1'b0};
  assign diff = trial - {1'b0, modulus};
  assign fits = trial >= {1'b0, modulus};
  assign rem_next = fits ? diff[STATE_W-1:0] : trial[STATE_W-1:0];

  assign count_inc = {1'b0, count} + 1'b1;
  assign run_end = count_inc >= {1'b0, run_length};

  assign mod_zero = modulus == '0;
  assign frac_top = gstate >> SHIFT;
  assign frac_out = mod_zero ? FRACTION_W'(frac_top) : FRACTION_W'(quo);

  assign status.mod_zero = mod_zero;
  assign status.can_push = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= RST_MULTIPLIER;
      modulus <= RST_MODULUS;
      run_length <= RST_RUN_LENGTH;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MULTIPLIER: mult <= cfg_data[MULT_W-1:0];
        REG_MODULUS: modulus <= cfg_data[STATE_W-1:0];
        REG_RUN_LENGTH: run_length <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= RST_STATE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        gstate <= seed_value;
        count <= '0;
      end else if (cmd.save_state) begin
        gstate <= mod_zero ? acc : rem;
      end
      if (cmd.push) begin
        count <= run_end ? '0 : count_inc[RUN_W-1:0];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      acc <= STATE_W'(prod_part);
    end else if (cmd.mul_hi) begin
      acc <= acc + {prod_part[HALF_W-1:0], {HALF_W{1'b0}}};
    end else if (cmd.rem_step) begin
      acc <= acc << 1;
    end
    if (cmd.mul_hi) begin
      rem <= '0;
    end else if (cmd.rem_step || cmd.frac_step) begin
      rem <= rem_next;
    end
    if (cmd.frac_step) begin
      quo <= {quo[FRACTION_BITS-2:0], fits};
    end
    if (cmd.push) begin
      state_value <= gstate;
      fraction <= frac_out;
      last <= run_end;
    end
  end

  `MCU_ASSERT_NEXT(a_state_reduced, clk, rst, cmd.save_state && !mod_zero, gstate < modulus, "saved state is not below the modulus")
  `MCU_ASSERT_NOW(a_push_room, clk, rst, cmd.push && out_valid, !out_stall, "result pushed over a stalled beat")
  `MCU_ASSERT_NEXT(a_seed_loaded, clk, rst, cmd.load_seed, count == '0, "run counter not cleared by a seed load")

endmodule

// File: rtl/mcu_ctrl.sv
// Sequencer of the uniform generator: input handshake, multiply, remainder
// and fraction iterations, and the push into the output register.
// Depends on mcu_pkg and the assertion macro header.
module mcu_ctrl #(
  parameter int FRACTION_BITS = mcu_pkg::DEF_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             mode,
  output logic             in_stall,
  input  mcu_pkg::status_t status,
  output mcu_pkg::cmd_t    cmd
);
  import mcu_pkg::*;
  `include "multiplicative_congruential_uniform_assert.svh"

  localparam int ITER_W = $clog2(STATE_W > FRACTION_BITS ? STATE_W : FRACTION_BITS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL_LO = 7'b0000010,
    S_MUL_HI = 7'b0000100,
    S_REM    = 7'b0001000,
    S_SAVE   = 7'b0010000,
    S_FRAC   = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic [ITER_W-1:0] iter;
  logic [ITER_W-1:0] iter_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    iter_next = iter;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_DRAW) begin
            state_next = S_MUL_LO;
          end else begin
            cmd.load_seed = 1'b1;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        if (status.mod_zero) begin
          state_next = S_SAVE;
        end else begin
          state_next = S_REM;
          iter_next = ITER_W'(STATE_W - 1);
        end
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (iter == '0) begin
          state_next = S_SAVE;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_SAVE: begin
        cmd.save_state = 1'b1;
        if (status.mod_zero) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_FRAC;
          iter_next = ITER_W'(FRACTION_BITS - 1);
        end
      end
      S_FRAC: begin
        cmd.frac_step = 1'b1;
        if (iter == '0) begin
          state_next = S_PUSH;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_PUSH: begin
        if (status.can_push) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter <= '0;
    end else begin
      state <= state_next;
      iter <= iter_next;
    end
  end

  `MCU_ASSERT_NEXT(a_draw_starts, clk, rst, state == S_IDLE && in_valid && mode == MODE_DRAW, state == S_MUL_LO, "accepted draw did not start the multiply")
  `MCU_ASSERT_NEXT(a_rem_ends, clk, rst, state == S_REM && iter == '0, state == S_SAVE, "remainder pass did not end after its last step")
  `MCU_ASSERT_NEXT(a_push_idle, clk, rst, cmd.push, state == S_IDLE && !in_stall, "sequencer did not return to idle after a push")

endmodule

// File: rtl/multiplicative_congruential_uniform.sv
// Multiplicative congruential uniform generator with a seed-load channel,
// a result channel and a plain configuration write port.
// Top level; depends on mcu_pkg, mcu_ctrl and mcu_datapath.
//
// Usage: an input beat with mode 0 loads seed_value into the generator state
// and clears the run counter; it gives no result. A beat
// with mode 1 draws one number: state = (multiplier * state mod 2^64) mod
// modulus, with fraction = floor(state * 2^FRACTION_BITS / modulus) and last
// set on the final draw of each run of run_length draws.
// A draw accepts the beat, runs the multiply (one 31x32 multiplier used twice),
// a bit-serial remainder pass over the 64-bit product and a divide pass of
// FRACTION_BITS quotient bits (one restoring subtractor, one bit per cycle),
// then saves the new state and pushes the result into the output register.
// A zero modulus is taken as 2^64 and skips both serial passes. in_stall is low
// only while no draw is in progress. The finished beat sits in an output
// register, so the next draw runs while it waits; if out_stall is still high
// when that draw ends, the sequencer holds it until the register frees. Reset
// restores multiplier 16807, modulus 2147483647, run_length 100, state 1 and
// run counter 0. Write configuration only idle.
module multiplicative_congruential_uniform #(
  parameter int FRACTION_BITS = mcu_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mcu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [mcu_pkg::STATE_W-1:0]     seed_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcu_pkg::STATE_W-1:0]     state_value,
  output logic [mcu_pkg::FRACTION_W-1:0]  fraction,
  output logic                            last
);
  import mcu_pkg::*;

  cmd_t cmd;
  status_t status;

  mcu_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mcu_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .seed_value  (seed_value),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .state_value (state_value),
    .fraction    (fraction),
    .last        (last)
  );

endmodule
